[rtl/core/itrt_pkg.sv]
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared constants, types and helpers for the integer to radix text block.
// ----------------------------------------------------------------------------
package itrt_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_W    = 4;
    localparam int ADDR_W     = 5;
    localparam int CNT_W      = 6;
    localparam int RADIX_W    = 5;
    localparam int ALPHA_W    = 64;
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h4645444342413938;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic init_conv;
        logic div_start;
        logic store_digit;
        logic load_idx;
        logic load_sign;
        logic load_char;
    } itrt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic base_ok;
        logic div_done;
        logic conv_end;
        logic neg;
        logic out_full;
        logic idx_zero;
    } itrt_stat_t;

    function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] lo,
                                                     input logic [ALPHA_W-1:0] hi,
                                                     input logic [DIGIT_W-1:0] idx);
        logic [ALPHA_W-1:0] w;
        w = idx[DIGIT_W-1] ? hi : lo;
        return w[idx[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

[rtl/core/itrt_ram.sv]
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itrt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/itrt_div.sv]
// ----------------------------------------------------------------------------
// itrt_div
// Iterative restoring divider, 32-bit dividend by radix, four quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module itrt_div
    import itrt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [RADIX_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quotient,
    output logic [DIGIT_W-1:0] remainder
);

    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);

    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIGIT_W:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int k = 0; k < BITS_PER_STEP; k++) begin
                trial    = {rem_next, quo_next[VALUE_W-1]};
                quo_next = {quo_next[VALUE_W-2:0], 1'b0};
                if (trial >= divisor) begin
                    trial       = trial - divisor;
                    quo_next[0] = 1'b1;
                end
                rem_next = trial[DIGIT_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/itrt_dp.sv]
// ----------------------------------------------------------------------------
// itrt_dp
// Datapath: configuration registers, base check, divider, digit store and
// output register.
// ----------------------------------------------------------------------------
module itrt_dp
    import itrt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  itrt_cmd_t            cmd,
    output itrt_stat_t           st,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_wdata,
    input  logic [VALUE_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_W-1:0]    m_tdata,
    output logic                 m_tlast
);

    logic [RADIX_W-1:0] radix_reg;
    logic [ALPHA_W-1:0] alo_reg, ahi_reg;
    logic               base_ok_reg, base_ok_next;
    logic [CHAR_W-1:0]  chars [MAX_RADIX];

    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] mag_calc;
    logic               neg_reg;
    logic [CNT_W-1:0]   dcount_reg, dcount_next;
    logic [CNT_W-1:0]   idx_reg, idx_next, rd_idx;

    logic               div_done;
    logic [VALUE_W-1:0] div_quo, div_dividend;
    logic [DIGIT_W-1:0] div_rem, rd_digit;

    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            alo_reg   <= ALPHA_LOW_RESET;
            ahi_reg   <= ALPHA_HIGH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RADIX:      radix_reg <= cfg_wdata[RADIX_W-1:0];
                CFG_ALPHA_LOW:  alo_reg   <= cfg_wdata;
                CFG_ALPHA_HIGH: ahi_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_RADIX; i++) begin
            chars[i] = alpha_char(alo_reg, ahi_reg, DIGIT_W'(i));
        end
    end

    // base check over the first radix characters, registered
    always_comb begin
        base_ok_next = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            if (RADIX_W'(i) < radix_reg) begin
                if (chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS) begin
                    base_ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (RADIX_W'(j) < radix_reg && chars[j] == chars[i]) begin
                        base_ok_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_ok_reg <= 1'b0;
        end else begin
            base_ok_reg <= base_ok_next;
        end
    end

    // input and magnitude
    assign mag_calc = val_reg[VALUE_W-1] ? (VALUE_W'(0) - val_reg) : val_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            val_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg <= 1'b0;
        end else if (cmd.init_conv) begin
            neg_reg <= val_reg[VALUE_W-1];
        end
    end

    // divider
    assign div_dividend = cmd.init_conv ? mag_calc : div_quo;

    itrt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // digit store, least significant digit first
    always_comb begin
        dcount_next = dcount_reg;
        if (cmd.init_conv) begin
            dcount_next = '0;
        end else if (cmd.store_digit) begin
            dcount_next = dcount_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcount_reg <= '0;
        end else begin
            dcount_reg <= dcount_next;
        end
    end

    assign rd_idx = idx_reg - 1'b1;

    itrt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.store_digit),
        .waddr (dcount_reg[ADDR_W-1:0]),
        .wdata (div_rem),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (rd_digit)
    );

    // emit index counts down from the digit count
    always_comb begin
        idx_next = idx_reg;
        if (cmd.load_idx) begin
            idx_next = dcount_reg;
        end else if (cmd.load_char) begin
            idx_next = rd_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_sign || cmd.load_char) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load_sign) begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end else if (cmd.load_char) begin
            out_char_reg <= alpha_char(alo_reg, ahi_reg, rd_digit);
            out_last_reg <= (idx_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        st.base_ok  = base_ok_reg;
        st.div_done = div_done;
        st.conv_end = (div_quo == '0) || (dcount_reg == CNT_W'(MAX_DIGITS - 1));
        st.neg      = neg_reg;
        st.out_full = out_valid_reg;
        st.idx_zero = (idx_reg == '0);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dcount_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_store_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_digit |-> $past(div_done))
        else $error("digit stored without a finished division");

    a_char_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_char |-> (idx_reg != '0) && !out_valid_reg)
        else $error("character loaded with no digit left or output busy");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (idx_reg == '0))
        else $error("last character shown with digits still pending");
`endif

endmodule

[rtl/core/itrt_ctrl.sv]
// ----------------------------------------------------------------------------
// itrt_ctrl
// Controller: sequences input capture, base check, repeated division and
// character emission.
// ----------------------------------------------------------------------------
module itrt_ctrl
    import itrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  itrt_stat_t st,
    output itrt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;
    localparam logic [2:0] S_SEND  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (st.base_ok) begin
                    cmd.init_conv = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (st.div_done) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store_digit = 1'b1;
                if (st.conv_end) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_EMIT: begin
                cmd.load_idx = 1'b1;
                if (st.neg) begin
                    cmd.load_sign = 1'b1;
                    state_next    = S_SEND;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                // store read address settles this cycle
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.load_char = 1'b1;
                state_next    = S_SEND;
            end
            S_SEND: begin
                if (!st.out_full) begin
                    state_next = st.idx_zero ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/integer_to_radix_text_top.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// Converts a signed 32-bit value to text in a configured radix, one
// character per output beat, most significant digit first.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one value per beat; m_ channel returns its characters,
//   a leading '-' for a negative value, m_tlast on the final digit.
//   cfg_we/cfg_index/cfg_wdata write radix (0), alphabet_low (1) and
//   alphabet_high (2) while the block is idle; other indexes are ignored.
// timing:
//   one value at a time; s_tready is high only when the block is idle.
//   each digit takes a division on the shared divider (8 iterations of 4
//   quotient bits each); once all digits are stored, each one is read,
//   loaded and handed over as a character, most significant first.
//   an invalid base gives no output and frees the input.
// reset:
//   aresetn low restores radix 10 and alphabet "0123456789ABCDEF" and drops
//   any conversion in progress; the digit store needs no clearing.
// stalls:
//   a character waits in the output register while m_tready is low and the
//   sequencer holds until it is taken.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top
    import itrt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,   // value (signed)
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_W-1:0]    m_tdata,   // out_char
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_wdata
);

    itrt_cmd_t  cmd;
    itrt_stat_t st;

    itrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    itrt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[sim/tb_integer_to_radix_text_top.sv]
// ----------------------------------------------------------------------------
// tb_integer_to_radix_text_top
// Self-checking bench for the integer to radix text converter. A short table
// of directed values and register writes runs first, then random phases, each
// with a fresh radix and alphabet, good or broken, followed by a burst of
// random values. Every character beat on the m_ side is compared with the
// text typed in the table, or that a local model predicts for the values accepted.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_text_top;
    import itrt_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_VALUES = 75;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_WRITE, ROW_CHECKED, ROW_TYPED} row_kind_t;

    typedef enum int {
        BASE_CLEAN, BASE_BAD_RADIX, BASE_SIGN, BASE_REPEAT, BASE_SIGN_UNUSED
    } base_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [ALPHA_W-1:0]   data;
        string                txt;
    } row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIX;
    logic [ALPHA_W-1:0]   cfg_wdata = '0;

    // local copy of the register file
    logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
    logic [ALPHA_W-1:0] cur_alo   = ALPHA_LOW_RESET;
    logic [ALPHA_W-1:0] cur_ahi   = ALPHA_HIGH_RESET;

    char_beat_t text_q[$];
    row_t       dir_rows[$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;
    int  stall_run   = 0;
    logic ready_level = 1'b1;

    integer_to_radix_text_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [ALPHA_W-1:0] half;
        half = d[DIGIT_W-1] ? cur_ahi : cur_alo;
        return half[d[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

    function automatic bit base_usable();
        logic [CHAR_W-1:0] c;
        if (cur_radix < 2 || cur_radix > MAX_RADIX) return 1'b0;
        for (int i = 0; i < cur_radix; i++) begin
            c = digit_char(DIGIT_W'(i));
            if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
            for (int j = i + 1; j < cur_radix; j++)
                if (digit_char(DIGIT_W'(j)) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // queue the characters that one value turns into
    task automatic predict_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digs[$];
        char_beat_t         b;
        if (!base_usable()) return;
        mag = v[VALUE_W-1] ? -v : v;
        do begin
            digs.push_back(DIGIT_W'(mag % cur_radix));
            mag = mag / cur_radix;
        end while (mag != 0);
        if (v[VALUE_W-1]) begin
            b.ch   = CHAR_MINUS;
            b.last = 1'b0;
            text_q.push_back(b);
        end
        while (digs.size() > 0) begin
            b.ch   = digit_char(digs.pop_back());
            b.last = (digs.size() == 0);
            text_q.push_back(b);
        end
    endtask

    task automatic push_value(input logic [VALUE_W-1:0] v, input bit typed, input string txt);
        char_beat_t b;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            for (int i = 0; i < txt.len(); i++) begin
                b.ch   = txt[i];
                b.last = (i == txt.len() - 1);
                text_q.push_back(b);
            end
        end else begin
            predict_text(v);
        end
    endtask

    // bursts of back-to-back beats, then a gap
    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // registers change only once all text is out and the block has settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RADIX:      cur_radix = data[RADIX_W-1:0];
            CFG_ALPHA_LOW:  cur_alo   = data;
            CFG_ALPHA_HIGH: cur_ahi   = data;
            default: ;
        endcase
    endtask

    // result side: check each beat, stall on a run-length pattern
    always @(posedge aclk) begin
        char_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (text_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected beat: char %h last %b", m_tdata, m_tlast);
            end else begin
                want = text_q.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("beat mismatch: expected char %h last %b, got char %h last %b",
                                 want.ch, want.last, m_tdata, m_tlast);
                end
            end
        end
        if (stall_run == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    ready_level = 1'b1;
                    stall_run   = $urandom_range(20, 80);
                end
                1: begin
                    ready_level = 1'b0;
                    stall_run   = $urandom_range(1, 15);
                end
                default: begin
                    ready_level = 1'($urandom_range(0, 1));
                    stall_run   = $urandom_range(1, 3);
                end
            endcase
        end else begin
            stall_run--;
        end
        m_tready <= ready_level;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_integer_to_radix_text_top: errors");
            $finish;
        end
    end

    initial begin
        logic [CHAR_W-1:0]  al[16];
        bit   [255:0]       taken;
        logic [RADIX_W-1:0] r;
        logic [ALPHA_W-1:0] lo;
        logic [ALPHA_W-1:0] hi;
        logic [ALPHA_W-1:0] rword;
        logic [VALUE_W-1:0] v;
        base_kind_t         kind;
        int                 k, i, j, n_items, good_items, phase_no;

        dir_rows = '{
            '{ROW_TYPED,   CFG_UNUSED,     64'h0000_0000, "0"},
            '{ROW_TYPED,   CFG_UNUSED,     64'h7FFF_FFFF, "2147483647"},
            '{ROW_TYPED,   CFG_UNUSED,     64'h8000_0000, "-2147483648"},
            '{ROW_TYPED,   CFG_UNUSED,     64'hFFFF_FFFF, "-1"},
            '{ROW_WRITE,   CFG_RADIX,      64'd16,        ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'h8000_0000, "-80000000"},
            '{ROW_TYPED,   CFG_UNUSED,     64'h7FFF_FFFF, "7FFFFFFF"},
            '{ROW_CHECKED, CFG_UNUSED,     64'hDEAD_BEEF, ""},
            '{ROW_WRITE,   CFG_RADIX,      64'd2,         ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'h8000_0000, "-10000000000000000000000000000000"},
            '{ROW_CHECKED, CFG_UNUSED,     64'h5555_5555, ""},
            // radix below two, zero and above the maximum: nothing comes out
            '{ROW_WRITE,   CFG_RADIX,      64'd1,         ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'd123,       ""},
            '{ROW_WRITE,   CFG_RADIX,      64'd0,         ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'hFFFF_FFFB, ""},
            '{ROW_WRITE,   CFG_RADIX,      64'd17,        ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'd5,         ""},
            // only the low five bits of the word set the radix
            '{ROW_WRITE,   CFG_RADIX,      64'hFFFF_FFFF_FFFF_FFE3, ""},
            '{ROW_CHECKED, CFG_UNUSED,     64'd100,       ""},
            '{ROW_WRITE,   CFG_RADIX,      64'd16,        ""},
            '{ROW_WRITE,   CFG_ALPHA_LOW,
              {ALPHA_LOW_RESET[63:24], CHAR_PLUS, ALPHA_LOW_RESET[15:0]}, ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'd7,         ""},
            '{ROW_WRITE,   CFG_ALPHA_LOW,  ALPHA_LOW_RESET, ""},
            '{ROW_WRITE,   CFG_ALPHA_HIGH, {CHAR_MINUS, ALPHA_HIGH_RESET[55:0]}, ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'd1,         ""},
            // the minus sign now lies past the digits in use
            '{ROW_WRITE,   CFG_RADIX,      64'd15,        ""},
            '{ROW_CHECKED, CFG_UNUSED,     64'hFFFF_FFF1, ""},
            // digit 8 repeats digit 0
            '{ROW_WRITE,   CFG_ALPHA_HIGH, {ALPHA_HIGH_RESET[63:8], 8'h30}, ""},
            '{ROW_TYPED,   CFG_UNUSED,     64'd3,         ""},
            '{ROW_WRITE,   CFG_RADIX,      64'd8,         ""},
            '{ROW_CHECKED, CFG_UNUSED,     64'h1234_5678, ""},
            // a zero byte is an ordinary digit
            '{ROW_WRITE,   CFG_ALPHA_LOW,  {ALPHA_LOW_RESET[63:8], 8'h00}, ""},
            '{ROW_CHECKED, CFG_UNUSED,     64'd0,         ""},
            '{ROW_CHECKED, CFG_UNUSED,     64'hFFFF_FFF8, ""},
            '{ROW_WRITE,   CFG_UNUSED,     64'd2,         ""},
            '{ROW_CHECKED, CFG_UNUSED,     64'h8000_0001, ""}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[n]) begin
            case (dir_rows[n].kind)
                ROW_WRITE: write_reg(dir_rows[n].idx, dir_rows[n].data);
                ROW_TYPED: begin
                    push_value(dir_rows[n].data[VALUE_W-1:0], 1'b1, dir_rows[n].txt);
                    sender_pause();
                end
                default: begin
                    push_value(dir_rows[n].data[VALUE_W-1:0], 1'b0, "");
                    sender_pause();
                end
            endcase
        end

        good_items = 0;
        phase_no   = 0;
        while (good_items < RANDOM_VALUES) begin
            // distinct digits with no sign among them
            taken = '0;
            taken[CHAR_PLUS]  = 1'b1;
            taken[CHAR_MINUS] = 1'b1;
            for (i = 0; i < 16; i++) begin
                do al[i] = 8'($urandom_range(0, 255)); while (taken[al[i]]);
                taken[al[i]] = 1'b1;
            end
            r = (phase_no == 0) ? 5'd2 : (phase_no == 1) ? 5'd16
                                       : RADIX_W'($urandom_range(2, 16));
            k = $urandom_range(0, 7);
            kind = (phase_no < 2 || k > 4) ? BASE_CLEAN : base_kind_t'(k);
            case (kind)
                BASE_BAD_RADIX:
                    r = RADIX_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                      : $urandom_range(17, 31));
                BASE_SIGN:
                    al[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
                BASE_REPEAT: begin
                    i = $urandom_range(1, r - 1);
                    j = $urandom_range(0, i - 1);
                    al[i] = al[j];
                end
                BASE_SIGN_UNUSED:
                    if (r < 16) al[$urandom_range(r, 15)] = CHAR_MINUS;
                default: ;
            endcase
            for (i = 0; i < 8; i++) begin
                lo[i*CHAR_W +: CHAR_W] = al[i];
                hi[i*CHAR_W +: CHAR_W] = al[8+i];
            end
            rword = {$urandom(), $urandom()};
            rword[RADIX_W-1:0] = r;
            write_reg(CFG_RADIX, rword);
            write_reg(CFG_ALPHA_LOW, lo);
            write_reg(CFG_ALPHA_HIGH, hi);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, {$urandom(), $urandom()});

            n_items = base_usable() ? $urandom_range(4, 14) : 2;
            repeat (n_items) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = $urandom();
                    4, 5, 6: begin
                        v = $urandom_range(0, 300);
                        if ($urandom_range(0, 1)) v = -v;
                    end
                    7: begin
                        v = $urandom() >> $urandom_range(1, 31);
                        if ($urandom_range(0, 1)) v = -v;
                    end
                    default: begin
                        case ($urandom_range(0, 5))
                            0: v = 32'h0000_0000;
                            1: v = 32'h7FFF_FFFF;
                            2: v = 32'h8000_0000;
                            3: v = 32'hFFFF_FFFF;
                            4: v = {27'd0, r} - 1;
                            default: v = -{27'd0, r};
                        endcase
                    end
                endcase
                push_value(v, 1'b0, "");
                if (base_usable()) good_items++;
                sender_pause();
            end
            phase_no++;
        end

        s_tvalid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (text_q.size() != 0)
            $display("%0d characters never arrived", text_q.size());
        fail_count += text_q.size();
        if (fail_count == 0) begin
            $display("tb_integer_to_radix_text_top: clean");
        end else begin
            $display("tb_integer_to_radix_text_top: errors");
        end
        $finish;
    end

endmodule
